FILE: hdl/prq_pkg.sv
// Package for the process run queue: sizes, codes, shared types and slot arithmetic.
`default_nettype none

package prq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int PID_W       = 22;
   localparam int ID_W        = 16;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_REM = 2'd2,
      OP_NOP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DEQ_DATA,
      S_SRCH_CHK,
      S_SHFT_WR
   } state_type;

   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic [ID_W-1:0]  id;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [PID_W-1:0] pid;
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] occupancy;
   } rsp_type;

   // circular slot index: base plus an offset of at most the depth
   function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/prq_slot_ram.sv
// Slot storage: one write port, one read port, registered read data.
`default_nettype none

module prq_slot_ram (
   input  wire logic                  clock,
   input  wire prq_pkg::mem_req_type  mem_req,
   output prq_pkg::entry_type         rd_data
);

   prq_pkg::entry_type slot_mem [prq_pkg::QUEUE_DEPTH];
   prq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= slot_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/prq_ctrl.sv
// Queue sequencer: head and count, id search and shift-down compaction over the slot RAM.
`default_nettype none

module prq_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [prq_pkg::PID_W-1:0]    req_new_pid,
   input  wire logic [prq_pkg::ID_W-1:0]     req_key_id,
   input  wire prq_pkg::entry_type           rd_data,
   output prq_pkg::mem_req_type              mem_req,
   output prq_pkg::rsp_type                  done
);

   prq_pkg::state_type          state_ff, state_in;
   prq_pkg::opcode_type         op_ff, op_in;
   logic [prq_pkg::PID_W-1:0]   pid_ff, pid_in;
   logic [prq_pkg::ID_W-1:0]    key_ff, key_in;
   logic [prq_pkg::IDX_W-1:0]   head_ff, head_in;
   logic [prq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [prq_pkg::CNT_W-1:0]   k_ff, k_in;
   prq_pkg::entry_type          hit_ff, hit_in;

   logic is_empty;
   logic is_full;
   logic is_match;
   logic more_after;   // an entry exists beyond position k
   logic more_shift;   // an entry exists beyond position k+1

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH));
   assign is_match   = (rd_data.id == key_ff);
   assign more_after = ((k_ff + prq_pkg::CNT_W'(1)) < count_ff);
   assign more_shift = ((k_ff + prq_pkg::CNT_W'(2)) < count_ff);
   assign busy       = (state_ff != prq_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pid_ff <= pid_in;
      key_ff <= key_in;
      k_ff   <= k_in;
      hit_ff <= hit_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prq_pkg::S_IDLE: begin
            if (start) state_in = prq_pkg::S_EXEC;
         end
         prq_pkg::S_EXEC: begin
            unique case (op_ff)
               prq_pkg::OP_DEQ: state_in = is_empty ? prq_pkg::S_IDLE : prq_pkg::S_DEQ_DATA;
               prq_pkg::OP_REM: state_in = is_empty ? prq_pkg::S_IDLE : prq_pkg::S_SRCH_CHK;
               default:         state_in = prq_pkg::S_IDLE;
            endcase
         end
         prq_pkg::S_DEQ_DATA: state_in = prq_pkg::S_IDLE;
         prq_pkg::S_SRCH_CHK: begin
            if (is_match) begin
               state_in = more_after ? prq_pkg::S_SHFT_WR : prq_pkg::S_IDLE;
            end else begin
               state_in = more_after ? prq_pkg::S_SRCH_CHK : prq_pkg::S_IDLE;
            end
         end
         prq_pkg::S_SHFT_WR: begin
            state_in = more_shift ? prq_pkg::S_SHFT_WR : prq_pkg::S_IDLE;
         end
         default: state_in = prq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in    = op_ff;
      pid_in   = pid_ff;
      key_in   = key_ff;
      head_in  = head_ff;
      count_in = count_ff;
      k_in     = k_ff;
      hit_in   = hit_ff;
      mem_req  = '0;
      done     = '0;
      done.status = prq_pkg::STAT_OK;

      unique case (state_ff)
         prq_pkg::S_IDLE: begin
            if (start) begin
               op_in  = prq_pkg::opcode_type'(req_opcode);
               pid_in = req_new_pid;
               key_in = req_key_id;
            end
         end
         prq_pkg::S_EXEC: begin
            unique case (op_ff)
               prq_pkg::OP_ENQ: begin
                  done.valid = 1'b1;
                  if (is_full) begin
                     done.status = prq_pkg::STAT_FULL;
                  end else begin
                     mem_req.wr_en       = 1'b1;
                     mem_req.wr_addr     = prq_pkg::slot_add(head_ff, count_ff);
                     mem_req.wr_data.pid = pid_ff;
                     mem_req.wr_data.id  = key_ff;
                     count_in            = count_ff + prq_pkg::CNT_W'(1);
                  end
               end
               prq_pkg::OP_DEQ, prq_pkg::OP_REM: begin
                  if (is_empty) begin
                     done.valid  = 1'b1;
                     done.status = prq_pkg::STAT_EMPTY;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     k_in            = '0;
                  end
               end
               default: done.valid = 1'b1;
            endcase
         end
         prq_pkg::S_DEQ_DATA: begin
            done.valid = 1'b1;
            done.pid   = rd_data.pid;
            done.id    = rd_data.id;
            head_in    = prq_pkg::slot_add(head_ff, prq_pkg::CNT_W'(1));
            count_in   = count_ff - prq_pkg::CNT_W'(1);
         end
         prq_pkg::S_SRCH_CHK: begin
            if (is_match) begin
               hit_in = rd_data;
               if (more_after) begin
                  // fetch the first entry to slide down into slot k
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = prq_pkg::slot_add(head_ff, k_ff + prq_pkg::CNT_W'(1));
               end else begin
                  done.valid = 1'b1;
                  done.pid   = rd_data.pid;
                  done.id    = rd_data.id;
                  count_in   = count_ff - prq_pkg::CNT_W'(1);
               end
            end else if (more_after) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = prq_pkg::slot_add(head_ff, k_ff + prq_pkg::CNT_W'(1));
               k_in            = k_ff + prq_pkg::CNT_W'(1);
            end else begin
               done.valid  = 1'b1;
               done.status = prq_pkg::STAT_NOT_FOUND;
            end
         end
         prq_pkg::S_SHFT_WR: begin
            // write k from k+1 while reading k+2: never the same slot
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = prq_pkg::slot_add(head_ff, k_ff);
            mem_req.wr_data = rd_data;
            k_in            = k_ff + prq_pkg::CNT_W'(1);
            if (more_shift) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = prq_pkg::slot_add(head_ff, k_ff + prq_pkg::CNT_W'(2));
            end else begin
               done.valid = 1'b1;
               done.pid   = hit_ff.pid;
               done.id    = hit_ff.id;
               count_in   = count_ff - prq_pkg::CNT_W'(1);
            end
         end
         default: ;
      endcase

      done.occupancy = count_in;
   end

endmodule

`default_nettype wire

FILE: hdl/process_run_queue.sv
// Top level of the process run queue: sequencer, slot RAM and result register.
`default_nettype none
//
// Bounded FIFO run queue of (pid, id) entries with removal by id.
//
// Request channel: req_opcode, req_new_pid, req_key_id are taken at a rising
// edge with start high and busy low. Opcodes: enqueue at tail, dequeue head,
// remove first entry matching req_key_id, and a no-op code.
// Result channel: one result per request, shown for exactly one cycle with
// rsp_strobe high; the receiver cannot hold it off. Every transfer yields
// status, the dequeued/removed entry (zero unless status is ok) and the
// occupancy after the operation.
//
// Steps after the accepting edge: the request runs in S_EXEC, and the result
// register shows its result. Enqueue, no-op and any failure on an empty queue
// finish in S_EXEC; dequeue reads the head slot there and finishes in
// S_DEQ_DATA; remove reads slots in S_SRCH_CHK up to the match, or to the
// last entry when not found, then moves the later entries down in S_SHFT_WR.
// The slot RAM, one read and one write per cycle, sets the pace: the search reads
// one slot per cycle, the compaction moves one slot per cycle (write k, read k+2).
// busy drops in the strobe cycle, so a new request may be taken then.
// Reset (synchronous): head and count cleared, queue empty; slot contents
// are left as they are and never read before being written.
//

module process_run_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [prq_pkg::PID_W-1:0]   req_new_pid,
   input  wire logic [prq_pkg::ID_W-1:0]    req_key_id,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [prq_pkg::PID_W-1:0]        rsp_out_pid,
   output logic [prq_pkg::ID_W-1:0]         rsp_out_id,
   output logic [prq_pkg::CNT_W-1:0]        rsp_occupancy
);

   prq_pkg::mem_req_type  mem_req;
   prq_pkg::entry_type    rd_data;
   prq_pkg::rsp_type      done;

   // result register: one-cycle strobe, payload valid only in that cycle
   logic                        rsp_strobe_ff;
   logic [1:0]                  rsp_status_ff;
   logic [prq_pkg::PID_W-1:0]   rsp_pid_ff;
   logic [prq_pkg::ID_W-1:0]    rsp_id_ff;
   logic [prq_pkg::CNT_W-1:0]   rsp_occ_ff;

   prq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_new_pid (req_new_pid),
      .req_key_id  (req_key_id),
      .rd_data     (rd_data),
      .mem_req     (mem_req),
      .done        (done)
   );

   prq_slot_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_status_ff <= done.status;
         rsp_pid_ff    <= done.pid;
         rsp_id_ff     <= done.id;
         rsp_occ_ff    <= done.occupancy;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_pid   = rsp_pid_ff;
   assign rsp_out_id    = rsp_id_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

`default_nettype wire

FILE: hdl/prq_checker.sv
// Port-level checker for the process run queue, bound to the top level.
`default_nettype none

module prq_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire logic [1:0]                  rsp_status,
   input wire logic [prq_pkg::PID_W-1:0]   rsp_out_pid,
   input wire logic [prq_pkg::ID_W-1:0]    rsp_out_id,
   input wire logic [prq_pkg::CNT_W-1:0]   rsp_occupancy
);

   // an accepted request keeps the block busy until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but busy not raised");

   // the block is free again in the cycle its result is shown
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   // failed operations return no entry
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != prq_pkg::STAT_OK))
         |-> ((rsp_out_pid == '0) && (rsp_out_id == '0)))
      else $error("failed operation returned an entry");

   // full and empty reports agree with the occupancy
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == prq_pkg::STAT_FULL))
         |-> (rsp_occupancy == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH)))
      else $error("full status with queue not full");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == prq_pkg::STAT_EMPTY)) |-> (rsp_occupancy == '0))
      else $error("empty status with entries present");

endmodule

bind process_run_queue prq_checker u_prq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_out_pid   (rsp_out_pid),
   .rsp_out_id    (rsp_out_id),
   .rsp_occupancy (rsp_occupancy)
);

`default_nettype wire
